FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset
`define QRPY_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset
`define QRPY_NEVER(lbl, clk_i, rst_ni, cond, msg) \
  `QRPY_ASSERT(lbl, clk_i, rst_ni, !(cond), msg)

`endif

FILE: sv/qrpy_pkg.sv
package qrpy_pkg;

  // CORDIC datapath width and angle width (Q2.30 plus the pi offset)
  localparam int CW = 40;
  localparam int AW = 34;

  // Square root: 62-bit radicand, 31-bit root, one root bit per stage
  localparam int SQ_IN_W     = 62;
  localparam int SQ_OUT_W    = 31;
  localparam int SQRT_STAGES = 31;

  localparam logic signed [AW-1:0] PI_Q30 = 34'sd3373259426;
  // 180/pi in Q.24
  localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;

  typedef struct packed {
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [33:0] yn;
    logic signed [33:0] yd;
  } geo_t;

  // atan(2^-i) in Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/qrpy_isqrt.sv
module qrpy_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [qrpy_pkg::SQ_IN_W-1:0]  in_val,
  output logic                          out_vld,
  output logic [qrpy_pkg::SQ_OUT_W-1:0] out_root
);

  localparam int N  = qrpy_pkg::SQRT_STAGES;
  localparam int RW = qrpy_pkg::SQ_OUT_W + 2;

  logic                          vld_r  [0:N-1];
  logic [RW-1:0]                 rem_r  [0:N-1];
  logic [qrpy_pkg::SQ_OUT_W-1:0] root_r [0:N-1];
  logic [qrpy_pkg::SQ_IN_W-1:0]  val_r  [0:N-1];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic                          vld_i;
      logic [RW-1:0]                 rem_i;
      logic [qrpy_pkg::SQ_OUT_W-1:0] root_i;
      logic [qrpy_pkg::SQ_IN_W-1:0]  val_i;
      logic [RW+1:0]                 rem_sh;
      logic [RW+1:0]                 trial;
      logic                          take;

      if (k == 0) begin : g_first
        assign vld_i  = in_vld;
        assign rem_i  = '0;
        assign root_i = '0;
        assign val_i  = in_val;
      end else begin : g_next
        assign vld_i  = vld_r[k-1];
        assign rem_i  = rem_r[k-1];
        assign root_i = root_r[k-1];
        assign val_i  = val_r[k-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign rem_sh = {rem_i, val_i[qrpy_pkg::SQ_IN_W-1 -: 2]};
      assign trial  = {2'b00, root_i, 2'b01};
      assign take   = rem_sh >= trial;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else begin
          vld_r[k] <= vld_i;
        end
        rem_r[k]  <= take ? RW'(rem_sh - trial) : RW'(rem_sh);
        root_r[k] <= {root_i[qrpy_pkg::SQ_OUT_W-2:0], take};
        val_r[k]  <= {val_i[qrpy_pkg::SQ_IN_W-3:0], 2'b00};
      end
    end
  endgenerate

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1];

endmodule

FILE: sv/qrpy_cordic.sv
module qrpy_cordic #(
  parameter int STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic signed [qrpy_pkg::CW-1:0]      in_y,
  input  logic signed [qrpy_pkg::CW-1:0]      in_x,
  output logic                                out_vld,
  output logic signed [qrpy_pkg::AW-1:0]      out_angle
);

  localparam int CW = qrpy_pkg::CW;
  localparam int AW = qrpy_pkg::AW;

  logic                 vld_r [0:STAGES];
  logic                 zf_r  [0:STAGES];
  logic signed [CW-1:0] x_r   [0:STAGES];
  logic signed [CW-1:0] y_r   [0:STAGES];
  logic signed [AW-1:0] z_r   [0:STAGES];

  // fold the left half plane onto the right, start z at the offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    zf_r[0] <= (in_x == '0) && (in_y == '0);
    if (in_x < 0) begin
      x_r[0] <= -in_x;
      y_r[0] <= -in_y;
      z_r[0] <= (in_y >= 0) ? qrpy_pkg::PI_Q30 : -qrpy_pkg::PI_Q30;
    end else begin
      x_r[0] <= in_x;
      y_r[0] <= in_y;
      z_r[0] <= '0;
    end
  end

  genvar i;
  generate
    for (i = 0; i < STAGES; i++) begin : g_rot
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      logic signed [AW-1:0] da;

      assign xs = x_r[i] >>> i;
      assign ys = y_r[i] >>> i;
      assign da = AW'(qrpy_pkg::atan_q30(5'(i)));

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i+1] <= 1'b0;
        end else begin
          vld_r[i+1] <= vld_r[i];
        end
        zf_r[i+1] <= zf_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + da;
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - da;
        end
      end
    end
  endgenerate

  assign out_vld   = vld_r[STAGES];
  assign out_angle = zf_r[STAGES] ? '0 : z_r[STAGES];

endmodule

FILE: sv/quaternion_to_roll_pitch_yaw_unit.sv
// Channel   Ports                                   Beat taken when
// input     in_quat_w/x/y/z, start, busy            start && !busy
// result    out_roll/pitch/yaw_angle, out_valid     out_valid (one cycle)
// config    cfg_wr_en, cfg_wr_data (in_degrees)     cfg_wr_en
//
// One quaternion enters every cycle; busy is never raised.
// The pipeline runs through the products and squares, the 31-stage square root,
// the CORDIC and the output scaling.
// Synchronous active-low reset clears the valid bits and in_degrees.
// The receiver cannot stall; each result is shown for one cycle only.
`include "assert_macros.svh"

module quaternion_to_roll_pitch_yaw_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  output logic signed [31:0] out_roll_angle,
  output logic signed [31:0] out_pitch_angle,
  output logic signed [31:0] out_yaw_angle,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  localparam int CW  = qrpy_pkg::CW;
  localparam int AW  = qrpy_pkg::AW;
  localparam int SQN = qrpy_pkg::SQRT_STAGES;
  localparam int LAT = 9 + SQN + CORDIC_STAGES;

  logic deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= 1'b0;
    end else if (cfg_wr_en) begin
      deg_r <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // ---- front end: products, gravity vector, squares ----
  logic               v0_r, v1_r, v2_r, v3_r, v4_r;
  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [31:0] p_ww_r, p_xx_r, p_yy_r, p_zz_r, p_xz_r;
  logic signed [31:0] p_wy_r, p_wx_r, p_yz_r, p_xy_r, p_wz_r;
  qrpy_pkg::geo_t     geo2_r, geo3_r, geo4_r;
  logic signed [31:0] gz2_r;
  logic [qrpy_pkg::SQ_IN_W-1:0] sq_gx_r, sq_gy_r, sq_gz_r;
  logic [qrpy_pkg::SQ_IN_W-1:0] sum_p_r, sum_r_r;

  logic signed [32:0] d_gx, d_gy, s_wx2;
  logic signed [33:0] d_gz;
  logic signed [32:0] d_yn;
  qrpy_pkg::geo_t     geo2_nxt;
  logic signed [63:0] m_gx, m_gy, m_gz;

  always_comb begin
    d_gx  = 33'(p_xz_r) - 33'(p_wy_r);
    d_gy  = 33'(p_wx_r) + 33'(p_yz_r);
    d_gz  = 34'(p_ww_r) - 34'(p_xx_r) - 34'(p_yy_r) + 34'(p_zz_r);
    d_yn  = 33'(p_xy_r) - 33'(p_wz_r);
    s_wx2 = 33'(p_ww_r) + 33'(p_xx_r);
    geo2_nxt.gx = 32'(d_gx >>> 1);
    geo2_nxt.gy = 32'(d_gy >>> 1);
    geo2_nxt.yn = {d_yn, 1'b0};
    geo2_nxt.yd = $signed({s_wx2, 1'b0}) - 34'sd268435456;
  end

  // square the gravity parts of the same beat side by side
  assign m_gx = geo2_r.gx * geo2_r.gx;
  assign m_gy = geo2_r.gy * geo2_r.gy;
  assign m_gz = gz2_r * gz2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    qw_r    <= in_quat_w;
    qx_r    <= in_quat_x;
    qy_r    <= in_quat_y;
    qz_r    <= in_quat_z;
    p_ww_r  <= qw_r * qw_r;
    p_xx_r  <= qx_r * qx_r;
    p_yy_r  <= qy_r * qy_r;
    p_zz_r  <= qz_r * qz_r;
    p_xz_r  <= qx_r * qz_r;
    p_wy_r  <= qw_r * qy_r;
    p_wx_r  <= qw_r * qx_r;
    p_yz_r  <= qy_r * qz_r;
    p_xy_r  <= qx_r * qy_r;
    p_wz_r  <= qw_r * qz_r;
    geo2_r  <= geo2_nxt;
    gz2_r   <= 32'(d_gz >>> 2);
    geo3_r  <= geo2_r;
    sq_gx_r <= m_gx[qrpy_pkg::SQ_IN_W-1:0];
    sq_gy_r <= m_gy[qrpy_pkg::SQ_IN_W-1:0];
    sq_gz_r <= m_gz[qrpy_pkg::SQ_IN_W-1:0];
    geo4_r  <= geo3_r;
    sum_p_r <= sq_gy_r + sq_gz_r;
    sum_r_r <= sq_gx_r + sq_gz_r;
  end

  // ---- square roots, with the other operands held alongside ----
  logic                          sq_vld, sq_vld_unused;
  logic [qrpy_pkg::SQ_OUT_W-1:0] root_p, root_r;
  qrpy_pkg::geo_t                geo_dl_r [0:SQN-1];

  qrpy_isqrt u_sqrt_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v4_r),
    .in_val   (sum_p_r),
    .out_vld  (sq_vld),
    .out_root (root_p)
  );

  qrpy_isqrt u_sqrt_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v4_r),
    .in_val   (sum_r_r),
    .out_vld  (sq_vld_unused),
    .out_root (root_r)
  );

  always_ff @(posedge clk) begin
    geo_dl_r[0] <= geo4_r;
    for (int k = 1; k < SQN; k++) begin
      geo_dl_r[k] <= geo_dl_r[k-1];
    end
  end

  // ---- arctangents ----
  logic                 cv_roll, cv_pitch, cv_yaw;
  logic signed [AW-1:0] ang [0:2];

  qrpy_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (sq_vld),
    .in_y      (CW'(geo_dl_r[SQN-1].gy)),
    .in_x      ($signed(CW'(root_r))),
    .out_vld   (cv_roll),
    .out_angle (ang[0])
  );

  qrpy_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (sq_vld),
    .in_y      (CW'(geo_dl_r[SQN-1].gx)),
    .in_x      ($signed(CW'(root_p))),
    .out_vld   (cv_pitch),
    .out_angle (ang[1])
  );

  qrpy_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (sq_vld),
    .in_y      (CW'(geo_dl_r[SQN-1].yn)),
    .in_x      (CW'(geo_dl_r[SQN-1].yd)),
    .out_vld   (cv_yaw),
    .out_angle (ang[2])
  );

  // ---- scaling to Q16.16, radians or degrees ----
  logic              c1_r, c2_r, c3_r;
  logic              neg1_r [0:2];
  logic              neg2_r [0:2];
  logic [AW-1:0]     mag_r  [0:2];
  logic [46:0]       pph_r  [0:2];
  logic [46:0]       ppl_r  [0:2];
  logic [19:0]       rad_r  [0:2];
  logic signed [31:0] res_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= 1'b0;
      c2_r <= 1'b0;
      c3_r <= 1'b0;
    end else begin
      c1_r <= cv_pitch;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  genvar j;
  generate
    for (j = 0; j < 3; j++) begin : g_fmt
      logic [AW-1:0] rad_sum;
      logic [63:0]   deg_sum;
      logic [31:0]   mag_out;

      assign rad_sum = mag_r[j] + AW'(1 << 13);
      assign deg_sum = {pph_r[j], 17'b0} + 64'(ppl_r[j]) + (64'd1 << 37);
      assign mag_out = deg_r ? 32'(deg_sum >> 38) : 32'(rad_r[j]);

      always_ff @(posedge clk) begin
        neg1_r[j] <= ang[j] < 0;
        mag_r[j]  <= (ang[j] < 0) ? AW'(-ang[j]) : AW'(ang[j]);
        neg2_r[j] <= neg1_r[j];
        pph_r[j]  <= mag_r[j][AW-1:17] * qrpy_pkg::DEG_PER_RAD_Q24;
        ppl_r[j]  <= mag_r[j][16:0] * qrpy_pkg::DEG_PER_RAD_Q24;
        rad_r[j]  <= rad_sum[AW-1:14];
        res_r[j]  <= neg2_r[j] ? -$signed(mag_out) : $signed(mag_out);
      end
    end
  endgenerate

  assign out_valid       = c3_r;
  assign out_roll_angle  = res_r[0];
  assign out_pitch_angle = res_r[1];
  assign out_yaw_angle   = res_r[2];

  `QRPY_NEVER(a_never_busy, clk, rst_n, busy, "busy raised")
  `QRPY_ASSERT(a_lanes_aligned, clk, rst_n, cv_pitch == cv_roll && cv_pitch == cv_yaw && sq_vld == sq_vld_unused, "angle lanes out of step")
  `QRPY_ASSERT(a_out_from_beat, clk, rst_n, out_valid |-> $past(start && !busy, LAT), "result without an input beat")
  `QRPY_ASSERT(a_pitch_range, clk, rst_n, out_valid |-> ($signed(out_pitch_angle) <= 32'sd6600000 && $signed(out_pitch_angle) >= -32'sd6600000), "pitch beyond the CORDIC range")

endmodule
